>>> sv/cosim_pkg.sv
// shared types and constants for the cosine similarity accumulator
package cosim_pkg;

    localparam int ELEM_WIDTH  = 16;
    localparam int SIM_WIDTH   = 16;
    localparam int DEF_MAX_LEN = 4096;

    // shared multiplier operand width: signed elements and unsigned 32-bit roots
    localparam int MUL_WIDTH   = 33;
    // normalized sums of squares and the divider remainder
    localparam int NORM_WIDTH  = 64;
    localparam int REM_WIDTH   = 66;
    localparam int ROOT_WIDTH  = 32;
    localparam int QUO_WIDTH   = 19;
    localparam int STEP_WIDTH  = 5;

    localparam int ROOT_STEPS  = 32;
    localparam int DIV_STEPS   = 19;

    localparam logic signed [SIM_WIDTH-1:0] SIM_POS_ONE = 16'sh7FFF;
    localparam logic signed [SIM_WIDTH-1:0] SIM_NEG_ONE = 16'sh8000;
    localparam logic signed [SIM_WIDTH-1:0] SIM_ZERO    = 16'sh0000;

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] elem_a;
        logic signed [ELEM_WIDTH-1:0] elem_b;
        logic                         last;
    } in_t;

    typedef struct packed {
        logic signed [SIM_WIDTH-1:0] similarity;
        logic                        overlong;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_DOT,
        ST_ADD,
        ST_CHECK,
        ST_NORM,
        ST_ROOT,
        ST_DEN,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

>>> sv/cosine_similarity_accumulator_core.sv
// cosine similarity of two streamed vectors, one shared multiplier and subtractor
//
//  channel | ports                     | payload  | direction
//  --------+---------------------------+----------+----------
//  input   | s_valid s_ready s_data    | in_t     | in
//  result  | m_valid m_ready m_data    | out_t    | out
//
// a pair is accepted while idle, then steps through SQ_A, SQ_B, DOT and ADD: the
//   shared multiplier forms a*a, b*b, a*b and the accumulator adders add them
// the pair marked last adds the closing phase: a check state, per norm the
//   normalizing shifts and the root steps on the shared subtractor, then the
//   denominator multiply, the divide steps and a rounding state
// an all-zero norm skips the closing math and gives its result after the check
// reset clears the sequencer, accumulators, pair count and overlong flag
// s_ready is high only while idle; the result is held in a register until taken
module cosine_similarity_accumulator_core #(
    parameter int MAX_LEN = cosim_pkg::DEF_MAX_LEN
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cosim_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output cosim_pkg::out_t  m_data
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int ACC_W = 2 * cosim_pkg::ELEM_WIDTH + $clog2(MAX_LEN) + 1;
    localparam int EW    = cosim_pkg::ELEM_WIDTH;
    localparam int MW    = cosim_pkg::MUL_WIDTH;
    localparam int NW    = cosim_pkg::NORM_WIDTH;
    localparam int RW    = cosim_pkg::REM_WIDTH;
    localparam int QW    = cosim_pkg::QUO_WIDTH;
    localparam int SW    = cosim_pkg::STEP_WIDTH;
    localparam int TW    = cosim_pkg::ROOT_WIDTH;

    cosim_pkg::state_t state_reg, state_next;

    logic signed [EW-1:0]    a_reg, b_reg;
    logic                    last_reg;
    logic signed [ACC_W-1:0] dot_acc_reg;
    logic [ACC_W-1:0]        sqa_acc_reg, sqb_acc_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    over_reg;
    logic [NW-1:0]           prod_reg;
    logic [NW-1:0]           norm_reg;
    logic [NW-1:0]           res_reg;
    logic [RW-1:0]           rem_reg;
    logic [QW-1:0]           quo_reg;
    logic [SW-1:0]           step_reg;
    logic                    second_reg;
    logic [TW-1:0]           root_a_reg;
    logic                    neg_reg;
    cosim_pkg::out_t         out_reg;

    logic                    accept;
    logic                    full;
    logic                    step_done;
    logic                    norm_low;

    // shared multiplier
    logic signed [MW-1:0]    mul_a, mul_b;
    logic signed [2*MW-1:0]  mul_p;

    // shared subtractor
    logic [RW-1:0]           sub_a, sub_b;
    logic [RW:0]             sub_d;
    logic                    sub_ge;

    logic [NW-1:0]           root_bit;
    logic [NW-1:0]           res_step;
    logic [ACC_W-1:0]        dot_mag;
    logic [QW-2:0]           rnd_sum;
    logic [QW-3:0]           rnd;
    logic                    rnd_sat;
    logic signed [cosim_pkg::SIM_WIDTH-1:0] sim_val;

    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CNT_W'(MAX_LEN));
    assign step_done = (step_reg == '0);
    assign norm_low  = (norm_reg[NW-1:NW-4] == 4'd0);
    assign dot_mag   = dot_acc_reg[ACC_W-1] ? ACC_W'(-dot_acc_reg) : ACC_W'(dot_acc_reg);
    assign root_bit  = NW'(1) << {step_reg, 1'b0};
    assign mul_p     = mul_a * mul_b;
    assign sub_d     = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge    = !sub_d[RW];
    assign res_step  = (res_reg >> 1) | (sub_ge ? root_bit : '0);

    // round half up to 15 fraction bits; an integer part of two or more saturates
    assign rnd_sum   = {1'b0, quo_reg[QW-3:0]} + (QW-1)'(1);
    assign rnd       = rnd_sum[QW-2:1];
    assign rnd_sat   = (quo_reg[QW-1:QW-2] != 2'd0);

    always_comb begin
        if (neg_reg) begin
            if (rnd_sat || rnd > (QW-2)'(32768)) begin
                sim_val = cosim_pkg::SIM_NEG_ONE;
            end else begin
                sim_val = cosim_pkg::SIM_WIDTH'(-rnd);
            end
        end else begin
            if (rnd_sat || rnd > (QW-2)'(32767)) begin
                sim_val = cosim_pkg::SIM_POS_ONE;
            end else begin
                sim_val = cosim_pkg::SIM_WIDTH'(rnd);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cosim_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!full) begin
                        state_next = cosim_pkg::ST_SQ_A;
                    end else if (s_data.last) begin
                        state_next = cosim_pkg::ST_CHECK;
                    end
                end
            end
            cosim_pkg::ST_SQ_A: state_next = cosim_pkg::ST_SQ_B;
            cosim_pkg::ST_SQ_B: state_next = cosim_pkg::ST_DOT;
            cosim_pkg::ST_DOT:  state_next = cosim_pkg::ST_ADD;
            cosim_pkg::ST_ADD: begin
                state_next = last_reg ? cosim_pkg::ST_CHECK : cosim_pkg::ST_IDLE;
            end
            cosim_pkg::ST_CHECK: begin
                if (sqa_acc_reg == '0 || sqb_acc_reg == '0) begin
                    state_next = cosim_pkg::ST_OUT;
                end else begin
                    state_next = cosim_pkg::ST_NORM;
                end
            end
            cosim_pkg::ST_NORM: begin
                if (!norm_low) begin
                    state_next = cosim_pkg::ST_ROOT;
                end
            end
            cosim_pkg::ST_ROOT: begin
                if (step_done) begin
                    state_next = second_reg ? cosim_pkg::ST_DEN : cosim_pkg::ST_NORM;
                end
            end
            cosim_pkg::ST_DEN: state_next = cosim_pkg::ST_DIV;
            cosim_pkg::ST_DIV: begin
                if (step_done) begin
                    state_next = cosim_pkg::ST_FIN;
                end
            end
            cosim_pkg::ST_FIN: state_next = cosim_pkg::ST_OUT;
            cosim_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = cosim_pkg::ST_IDLE;
                end
            end
            default: state_next = cosim_pkg::ST_IDLE;
        endcase
    end

    // outputs and shared unit operand selection
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        sub_a   = rem_reg;
        sub_b   = {prod_reg, 2'b00};
        case (state_reg)
            cosim_pkg::ST_IDLE: s_ready = 1'b1;
            cosim_pkg::ST_SQ_A: begin
                mul_a = MW'(a_reg);
                mul_b = MW'(a_reg);
            end
            cosim_pkg::ST_SQ_B: begin
                mul_a = MW'(b_reg);
                mul_b = MW'(b_reg);
            end
            cosim_pkg::ST_DOT: begin
                mul_a = MW'(a_reg);
                mul_b = MW'(b_reg);
            end
            cosim_pkg::ST_ROOT: begin
                sub_a = RW'(norm_reg);
                sub_b = RW'(res_reg | root_bit);
            end
            cosim_pkg::ST_DEN: begin
                mul_a = signed'({1'b0, root_a_reg});
                mul_b = signed'({1'b0, res_reg[TW-1:0]});
            end
            cosim_pkg::ST_OUT: m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cosim_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // accumulators and pair count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_acc_reg <= '0;
            sqa_acc_reg <= '0;
            sqb_acc_reg <= '0;
            count_reg   <= '0;
            over_reg    <= 1'b0;
        end else begin
            case (state_reg)
                cosim_pkg::ST_IDLE: begin
                    if (accept) begin
                        if (full) begin
                            over_reg <= 1'b1;
                        end else begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                end
                cosim_pkg::ST_SQ_B: sqa_acc_reg <= sqa_acc_reg + prod_reg[ACC_W-1:0];
                cosim_pkg::ST_DOT:  sqb_acc_reg <= sqb_acc_reg + prod_reg[ACC_W-1:0];
                cosim_pkg::ST_ADD:  dot_acc_reg <= dot_acc_reg + signed'(prod_reg[ACC_W-1:0]);
                cosim_pkg::ST_OUT: begin
                    if (m_ready) begin
                        dot_acc_reg <= '0;
                        sqa_acc_reg <= '0;
                        sqb_acc_reg <= '0;
                        count_reg   <= '0;
                        over_reg    <= 1'b0;
                    end
                end
                default: begin
                    over_reg <= over_reg;
                end
            endcase
        end
    end

    // input and product registers, closing datapath: normalize, roots, denominator, long division, rounding
    always_ff @(posedge aclk) begin
        case (state_reg)
            cosim_pkg::ST_IDLE: begin
                if (accept) begin
                    a_reg    <= s_data.elem_a;
                    b_reg    <= s_data.elem_b;
                    last_reg <= s_data.last;
                end
            end
            cosim_pkg::ST_SQ_A, cosim_pkg::ST_SQ_B, cosim_pkg::ST_DOT: begin
                prod_reg <= mul_p[NW-1:0];
            end
            cosim_pkg::ST_CHECK: begin
                out_reg.overlong <= over_reg;
                neg_reg          <= dot_acc_reg[ACC_W-1];
                rem_reg          <= RW'(dot_mag);
                norm_reg         <= NW'(sqa_acc_reg);
                second_reg       <= 1'b0;
                if (sqa_acc_reg == '0 && sqb_acc_reg == '0) begin
                    out_reg.similarity <= cosim_pkg::SIM_POS_ONE;
                end else begin
                    out_reg.similarity <= cosim_pkg::SIM_ZERO;
                end
            end
            cosim_pkg::ST_NORM: begin
                // each scaling of a norm by 4 doubles the numerator
                if (norm_low) begin
                    norm_reg <= norm_reg << 2;
                    rem_reg  <= rem_reg << 1;
                end else begin
                    res_reg  <= '0;
                    step_reg <= SW'(cosim_pkg::ROOT_STEPS - 1);
                end
            end
            cosim_pkg::ST_ROOT: begin
                res_reg  <= res_step;
                step_reg <= step_reg - SW'(1);
                if (step_done && !second_reg) begin
                    root_a_reg <= res_step[TW-1:0];
                    norm_reg   <= NW'(sqb_acc_reg);
                    second_reg <= 1'b1;
                end else if (sub_ge) begin
                    norm_reg <= sub_d[NW-1:0];
                end
            end
            cosim_pkg::ST_DEN: begin
                prod_reg <= mul_p[NW-1:0];
                quo_reg  <= '0;
                step_reg <= SW'(cosim_pkg::DIV_STEPS - 1);
            end
            cosim_pkg::ST_DIV: begin
                rem_reg  <= sub_ge ? {sub_d[RW-2:0], 1'b0} : {rem_reg[RW-2:0], 1'b0};
                quo_reg  <= {quo_reg[QW-2:0], sub_ge};
                step_reg <= step_reg - SW'(1);
            end
            cosim_pkg::ST_FIN: out_reg.similarity <= sim_val;
            default: begin
                step_reg <= step_reg;
            end
        endcase
    end

    assign m_data = out_reg;

    // the input and result sides are never open at the same time
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    // pair count saturates at the maximum length
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("pair count beyond maximum length");

    // dropped pairs only once the vector is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        over_reg |-> full)
        else $error("overlong flag set before the vector filled");

    // normalized roots keep the divisor at or above 2^60
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cosim_pkg::ST_DIV) |-> (prod_reg[NW-1:NW-4] != 4'd0))
        else $error("divisor not normalized");

    // a delivered result leaves the block cleared for the next vector
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (count_reg == '0 && !over_reg && sqa_acc_reg == '0))
        else $error("accumulators not cleared after result transaction");

endmodule
